>>> rtl/dual_wheel_ramped_drive_command_macros.svh
// Assertion macros for the drive command block.
// The bodies refer to the clk and rst_n of the module that uses them.
`ifndef DUAL_WHEEL_RAMPED_DRIVE_COMMAND_MACROS_SVH
`define DUAL_WHEEL_RAMPED_DRIVE_COMMAND_MACROS_SVH
`ifndef SYNTH
`define DRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DRC_ASSERT_SAME(label, ante, cons, msg)
`define DRC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/drc_pkg.sv
package drc_pkg;

    // Fixed fraction bits of the speed gain.
    localparam int GAIN_FRAC_BITS = 8;
    // Largest motor command magnitude.
    localparam int CMD_MAX = 127;
    // Depth of the lane command pipeline that must refill after a change.
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    // Input beat selector and result kind codes.
    localparam logic CMD_SPEED   = 1'b0;
    localparam logic CMD_TICK    = 1'b1;
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Register reset values.
    localparam logic [14:0] SPEED_LIMIT_RST    = 15'd6144;
    localparam logic [15:0] SPEED_GAIN_RST     = 16'd21675;
    localparam logic [6:0]  DEADBAND_RST       = 7'd3;
    localparam logic [7:0]  SLEW_STEP_RST      = 8'd4;
    localparam logic [15:0] TIMEOUT_MS_RST     = 16'd250;
    localparam logic [15:0] LOOP_PERIOD_MS_RST = 16'd10;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SPEED_LIMIT    = 3'd0,
        REG_SPEED_GAIN     = 3'd1,
        REG_DEADBAND       = 3'd2,
        REG_SLEW_STEP      = 3'd3,
        REG_TIMEOUT_MS     = 3'd4,
        REG_LOOP_PERIOD_MS = 3'd5,
        REG_LEFT_INVERT    = 3'd6,
        REG_RIGHT_INVERT   = 3'd7
    } drc_reg_t;

    // Per-update control from the loop period and watchdog logic to both wheel lanes.
    typedef struct packed {
        logic update;
        logic stop;
    } drc_lane_ctl_t;

endpackage

>>> rtl/drc_lane.sv
module drc_lane
    import drc_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [15:0]  target,
    input  logic [14:0]         speed_limit,
    input  logic [15:0]         speed_gain,
    input  logic [6:0]          deadband,
    input  logic [7:0]          slew_step,
    input  logic                invert,
    input  drc_lane_ctl_t       ctl,
    output logic signed [7:0]   cmd_next
);

    localparam int SHIFT = SPEED_FRAC_BITS + GAIN_FRAC_BITS;

    logic [16:0]        neg_ext;
    logic [16:0]        abs_s;
    logic [14:0]        mag_a_reg;
    logic [14:0]        mag_a_next;
    logic               neg_a_reg;
    logic [30:0]        prod_b_reg;
    logic [30:0]        prod_b_next;
    logic               neg_b_reg;
    logic [30:0]        shifted;
    logic [6:0]         mag7;
    logic [7:0]         mag8;
    logic               neg_c;
    logic [7:0]         cmd_c_reg;
    logic [7:0]         cmd_c_next;
    logic signed [7:0]  current_reg;
    logic signed [7:0]  current_next;
    logic signed [9:0]  cur10;
    logic signed [9:0]  tgt10;
    logic signed [9:0]  step10;
    logic signed [9:0]  up10;
    logic signed [9:0]  dn10;
    logic signed [7:0]  slewed;

    // First stage: magnitude of the target clamped to the speed limit.
    always_comb
    begin
        neg_ext    = 17'd0 - {target[15], target};
        abs_s      = target[15] ? neg_ext : {1'b0, target};
        mag_a_next = (abs_s > {2'b00, speed_limit}) ? speed_limit : abs_s[14:0];
    end

    // Second stage: scale by the Q8.8 gain.
    assign prod_b_next = 31'(mag_a_reg) * 31'(speed_gain);

    // Third stage: drop fraction bits, clamp, apply direction and deadband.
    always_comb
    begin
        shifted    = prod_b_reg >> SHIFT;
        mag7       = (shifted > 31'(CMD_MAX)) ? 7'(CMD_MAX) : shifted[6:0];
        mag8       = {1'b0, mag7};
        neg_c      = neg_b_reg ^ invert;
        if (mag7 < deadband)
        begin
            cmd_c_next = 8'd0;
        end
        else
        begin
            cmd_c_next = neg_c ? (8'd0 - mag8) : mag8;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg  <= mag_a_next;
        neg_a_reg  <= target[15];
        prod_b_reg <= prod_b_next;
        neg_b_reg  <= neg_a_reg;
        cmd_c_reg  <= cmd_c_next;
    end

    // Slew limit: move the current command toward the goal by the step size.
    always_comb
    begin
        cur10  = {{2{current_reg[7]}}, current_reg};
        tgt10  = {{2{cmd_c_reg[7]}}, cmd_c_reg};
        step10 = {2'b00, slew_step};
        up10   = cur10 + step10;
        dn10   = cur10 - step10;
        if (tgt10 > up10)
        begin
            slewed = up10[7:0];
        end
        else if (tgt10 < dn10)
        begin
            slewed = dn10[7:0];
        end
        else
        begin
            slewed = tgt10[7:0];
        end
        cmd_next     = ctl.stop ? 8'sd0 : slewed;
        current_next = ctl.update ? cmd_next : current_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg <= 8'sd0;
        end
        else
        begin
            current_reg <= current_next;
        end
    end

endmodule

>>> rtl/dual_wheel_ramped_drive_command.sv
// Results land in the output register, or the skid stage on a stall. One tick
// beat per cycle unless stalled or refilling; the left and right lanes run side
// by side. A command beat or a register write holds the input off while the
// three-stage clamp, gain and deadband pipeline of each lane refills. Reset
// (async, rst_n low): registers return to defaults, targets, motor commands and
// both millisecond counters clear, output empty, input held off for the refill.
`include "dual_wheel_ramped_drive_command_macros.svh"
module dual_wheel_ramped_drive_command
    import drc_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = 12,
    parameter int TIMER_WIDTH     = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // left_target_speed[15:0],
                                             // right_target_speed[31:16]
    input  logic                  s_tuser,   // cmd
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // left_cmd[7:0], right_cmd[15:8],
                                             // timed_out[16], echo_left[32:17],
                                             // echo_right[48:33], zero[55:49]
    output logic                  m_tuser,   // kind
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    logic [14:0]             speed_limit_reg;
    logic [15:0]             speed_gain_reg;
    logic [6:0]              deadband_reg;
    logic [7:0]              slew_step_reg;
    logic [15:0]             timeout_ms_reg;
    logic [15:0]             loop_period_ms_reg;
    logic                    left_invert_reg;
    logic                    right_invert_reg;
    logic signed [15:0]      left_target_reg;
    logic signed [15:0]      right_target_reg;
    logic [TIMER_WIDTH-1:0]  ms_cmd_reg;
    logic [TIMER_WIDTH-1:0]  ms_cmd_next;
    logic [TIMER_WIDTH-1:0]  ms_upd_reg;
    logic [TIMER_WIDTH-1:0]  ms_upd_next;
    logic [TIMER_WIDTH-1:0]  cmd_inc;
    logic [TIMER_WIDTH-1:0]  upd_inc;
    logic [1:0]              settle_reg;
    logic [1:0]              settle_next;
    logic                    in_acc;
    logic                    cmd_acc;
    logic                    tick;
    logic                    due;
    logic                    timeout;
    drc_lane_ctl_t           lane_ctl;
    logic signed [7:0]       left_cmd;
    logic signed [7:0]       right_cmd;
    logic                    res_valid;
    logic                    res_kind;
    logic [OUT_DATA_W-1:0]   res_data;
    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    skid_valid_reg;
    logic                    skid_kind_reg;
    logic [OUT_DATA_W-1:0]   skid_data_reg;

    // Input handshake.
    assign s_tready = !skid_valid_reg && (settle_reg == 2'd0);
    assign in_acc   = s_tvalid && s_tready;
    assign cmd_acc  = in_acc && (s_tuser == CMD_SPEED);
    assign tick     = in_acc && (s_tuser == CMD_TICK);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg    <= SPEED_LIMIT_RST;
            speed_gain_reg     <= SPEED_GAIN_RST;
            deadband_reg       <= DEADBAND_RST;
            slew_step_reg      <= SLEW_STEP_RST;
            timeout_ms_reg     <= TIMEOUT_MS_RST;
            loop_period_ms_reg <= LOOP_PERIOD_MS_RST;
            left_invert_reg    <= 1'b0;
            right_invert_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (drc_reg_t'(cfg_index))
                REG_SPEED_LIMIT:    speed_limit_reg    <= cfg_data[14:0];
                REG_SPEED_GAIN:     speed_gain_reg     <= cfg_data;
                REG_DEADBAND:       deadband_reg       <= cfg_data[6:0];
                REG_SLEW_STEP:      slew_step_reg      <= cfg_data[7:0];
                REG_TIMEOUT_MS:     timeout_ms_reg     <= cfg_data;
                REG_LOOP_PERIOD_MS: loop_period_ms_reg <= cfg_data;
                REG_LEFT_INVERT:    left_invert_reg    <= cfg_data[0];
                REG_RIGHT_INVERT:   right_invert_reg   <= cfg_data[0];
                default:            speed_limit_reg    <= speed_limit_reg;
            endcase
        end
    end

    // Millisecond counters, loop period and watchdog decisions.
    always_comb
    begin
        cmd_inc     = (ms_cmd_reg == TIMER_MAX) ? ms_cmd_reg : ms_cmd_reg + 1'b1;
        upd_inc     = (ms_upd_reg == TIMER_MAX) ? ms_upd_reg : ms_upd_reg + 1'b1;
        due         = CMP_W'(upd_inc) >= CMP_W'(loop_period_ms_reg);
        timeout     = CMP_W'(cmd_inc) > CMP_W'(timeout_ms_reg);
        ms_cmd_next = ms_cmd_reg;
        ms_upd_next = ms_upd_reg;
        if (cmd_acc)
        begin
            ms_cmd_next = '0;
        end
        else if (tick)
        begin
            ms_cmd_next = cmd_inc;
            ms_upd_next = due ? '0 : upd_inc;
        end
        if (cmd_acc || cfg_we)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
        lane_ctl.update = tick && due;
        lane_ctl.stop   = timeout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_target_reg  <= 16'sd0;
            right_target_reg <= 16'sd0;
            ms_cmd_reg       <= '0;
            ms_upd_reg       <= '0;
            settle_reg       <= SETTLE_CYCLES;
        end
        else
        begin
            if (cmd_acc)
            begin
                left_target_reg  <= s_tdata[15:0];
                right_target_reg <= s_tdata[31:16];
            end
            ms_cmd_reg <= ms_cmd_next;
            ms_upd_reg <= ms_upd_next;
            settle_reg <= settle_next;
        end
    end

    // Wheel lanes.
    drc_lane #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_left_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .target      (left_target_reg),
        .speed_limit (speed_limit_reg),
        .speed_gain  (speed_gain_reg),
        .deadband    (deadband_reg),
        .slew_step   (slew_step_reg),
        .invert      (left_invert_reg),
        .ctl         (lane_ctl),
        .cmd_next    (left_cmd)
    );

    drc_lane #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_right_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .target      (right_target_reg),
        .speed_limit (speed_limit_reg),
        .speed_gain  (speed_gain_reg),
        .deadband    (deadband_reg),
        .slew_step   (slew_step_reg),
        .invert      (right_invert_reg),
        .ctl         (lane_ctl),
        .cmd_next    (right_cmd)
    );

    // Merge lane results into one result beat.
    always_comb
    begin
        res_valid = cmd_acc || lane_ctl.update;
        if (cmd_acc)
        begin
            res_kind = KIND_ACK;
            res_data = {7'd0, s_tdata[31:16], s_tdata[15:0], 1'b0, 8'd0, 8'd0};
        end
        else
        begin
            res_kind = KIND_UPDATE;
            res_data = {7'd0, 16'd0, 16'd0, timeout, right_cmd, left_cmd};
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_kind_reg <= skid_kind_reg;
                out_data_reg <= skid_data_reg;
            end
            else
            begin
                out_kind_reg <= res_kind;
                out_data_reg <= res_data;
            end
        end
        else if (res_valid)
        begin
            skid_kind_reg <= res_kind;
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

    // Checks.
    `DRC_ASSERT_NEXT(a_hold_after_cmd, s_tvalid && s_tready && (s_tuser == CMD_SPEED),
        !s_tready, "input accepted while lane pipeline refills")
    `DRC_ASSERT_SAME(a_timeout_zero, m_tvalid && (m_tuser == KIND_UPDATE) && m_tdata[16],
        m_tdata[15:0] == 16'd0, "timed out update with nonzero motor command")
    `DRC_ASSERT_SAME(a_ack_clean, m_tvalid && (m_tuser == KIND_ACK),
        m_tdata[16:0] == 17'd0, "acknowledge carries drive fields")
    `DRC_ASSERT_SAME(a_cmd_range, m_tvalid && (m_tuser == KIND_UPDATE),
        (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80),
        "motor command outside plus or minus 127")

endmodule

>>> bench/drive_command_checker.sv
`timescale 1ns / 1ps
module drive_command_checker
    import drc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // left_target_speed[15:0],
                                             // right_target_speed[31:16]
    input  logic                  s_tuser,   // cmd
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // left_cmd[7:0], right_cmd[15:8], timed_out[16],
                                             // echo_left[32:17], echo_right[48:33]
    input  logic                  m_tuser,   // kind
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    // Speed fraction bits of the block as instantiated.
    localparam int SPEED_FRAC = 12;
    localparam logic [15:0] AGE_TOP = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  left_cmd;
        logic [7:0]  right_cmd;
        logic        timed_out;
        logic [15:0] ack_left;
        logic [15:0] ack_right;
    } drive_result_t;

    // Shadow copy of the register file.
    logic [14:0] lim_speed;
    logic [15:0] gain_q8;
    logic [6:0]  dead_zone;
    logic [7:0]  step_max;
    logic [15:0] watchdog_ms;
    logic [15:0] period_ms;
    logic        inv_left;
    logic        inv_right;

    // Shadow copy of the wheel state.
    logic signed [15:0] tgt_left;
    logic signed [15:0] tgt_right;
    logic signed [7:0]  cmd_left;
    logic signed [7:0]  cmd_right;
    logic [15:0]        cmd_age_ms;
    logic [15:0]        update_age_ms;

    drive_result_t due_results[$];

    // Clamp, scale, saturate, invert and deadband one wheel target.
    function automatic int wheel_command(input logic signed [15:0] speed, input logic inv);
        int     s;
        int     lim;
        int     c;
        longint mag;
        lim = int'(lim_speed);
        s = speed;
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        mag = (mag * longint'(gain_q8)) >> (SPEED_FRAC + GAIN_FRAC_BITS);
        if (mag > CMD_MAX) mag = CMD_MAX;
        c = (s < 0) ? -int'(mag) : int'(mag);
        if (inv) c = -c;
        if (((c < 0) ? -c : c) < int'(dead_zone)) c = 0;
        return c;
    endfunction

    // Move the current command toward the goal by at most one step.
    function automatic int ramp_toward(input int cur, input int goal);
        int st;
        st = int'(step_max);
        if (goal > cur + st) return cur + st;
        if (goal < cur - st) return cur - st;
        return goal;
    endfunction

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic report_field(input string what, input int got, input int want);
        report_mismatch($sformatf("%s is %0d, expected %0d", what, got, want));
    endtask

    task automatic compare_result(input drive_result_t want, input logic [OUT_DATA_W-1:0] data,
                                  input logic kind);
        if (kind !== want.kind)
            report_field("kind", kind, want.kind);
        if (data[7:0] !== want.left_cmd)
            report_field("left_cmd", $signed(data[7:0]), $signed(want.left_cmd));
        if (data[15:8] !== want.right_cmd)
            report_field("right_cmd", $signed(data[15:8]), $signed(want.right_cmd));
        if (data[16] !== want.timed_out)
            report_field("timed_out", data[16], want.timed_out);
        if (data[32:17] !== want.ack_left)
            report_field("echo_left", $signed(data[32:17]), $signed(want.ack_left));
        if (data[48:33] !== want.ack_right)
            report_field("echo_right", $signed(data[48:33]), $signed(want.ack_right));
    endtask

    // Work out what one accepted input beat produces.
    task automatic predict_beat(input logic cmd, input logic [15:0] left, input logic [15:0] right);
        drive_result_t r;
        r = '0;
        if (cmd == CMD_SPEED)
        begin
            tgt_left = left;
            tgt_right = right;
            cmd_age_ms = '0;
            r.kind = KIND_ACK;
            r.ack_left = left;
            r.ack_right = right;
            due_results.push_back(r);
        end
        else
        begin
            if (cmd_age_ms != AGE_TOP) cmd_age_ms++;
            if (update_age_ms != AGE_TOP) update_age_ms++;
            if (update_age_ms >= period_ms)
            begin
                update_age_ms = '0;
                r.kind = KIND_UPDATE;
                if (cmd_age_ms > watchdog_ms)
                begin
                    cmd_left = '0;
                    cmd_right = '0;
                    r.timed_out = 1'b1;
                end
                else
                begin
                    cmd_left = 8'(ramp_toward(cmd_left, wheel_command(tgt_left, inv_left)));
                    cmd_right = 8'(ramp_toward(cmd_right, wheel_command(tgt_right, inv_right)));
                end
                r.left_cmd = cmd_left;
                r.right_cmd = cmd_right;
                due_results.push_back(r);
            end
        end
    endtask

    // Watch all three ports: results first, then writes, then new input beats.
    always @(posedge clk)
    begin : watch
        drive_result_t want;
        if (!rst_n)
        begin
            lim_speed = SPEED_LIMIT_RST;
            gain_q8 = SPEED_GAIN_RST;
            dead_zone = DEADBAND_RST;
            step_max = SLEW_STEP_RST;
            watchdog_ms = TIMEOUT_MS_RST;
            period_ms = LOOP_PERIOD_MS_RST;
            inv_left = 1'b0;
            inv_right = 1'b0;
            tgt_left = '0;
            tgt_right = '0;
            cmd_left = '0;
            cmd_right = '0;
            cmd_age_ms = '0;
            update_age_ms = '0;
            due_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch("result beat with no result due");
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_result(want, m_tdata, m_tuser);
                end
            end
            if (cfg_we)
            begin
                case (drc_reg_t'(cfg_index))
                    REG_SPEED_LIMIT:    lim_speed = cfg_data[14:0];
                    REG_SPEED_GAIN:     gain_q8 = cfg_data;
                    REG_DEADBAND:       dead_zone = cfg_data[6:0];
                    REG_SLEW_STEP:      step_max = cfg_data[7:0];
                    REG_TIMEOUT_MS:     watchdog_ms = cfg_data;
                    REG_LOOP_PERIOD_MS: period_ms = cfg_data;
                    REG_LEFT_INVERT:    inv_left = cfg_data[0];
                    REG_RIGHT_INVERT:   inv_right = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_beat(s_tuser, s_tdata[15:0], s_tdata[31:16]);
        end
        outstanding = due_results.size();
    end

endmodule

>>> bench/tb_dual_wheel_ramped_drive_command.sv
`timescale 1ns / 1ps
module tb_dual_wheel_ramped_drive_command
    import drc_pkg::*;
();

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // left_target_speed[15:0], right_target_speed[31:16]
    logic                  s_tuser = CMD_TICK;   // cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;   // left_cmd[7:0], right_cmd[15:8], timed_out[16],
                                      // echo_left[32:17], echo_right[48:33]
    logic                  m_tuser;   // kind
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = REG_SPEED_LIMIT;
    logic [15:0]           cfg_data = '0;

    int mismatches;
    int outstanding;
    int send_gap_pct = 0;
    int stall_pct = 0;
    logic [14:0] cur_limit = SPEED_LIMIT_RST;

    always #5 clk = ~clk;

    dual_wheel_ramped_drive_command i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    drive_command_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Result side back-pressure.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Offer one input beat after a random gap and hold it until it is taken.
    task automatic push_beat(input logic cmd, input logic [15:0] left, input logic [15:0] right);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {right, left};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop sending, let every due result come out, then give the block time to settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input drc_reg_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic [14:0] lim, input logic [15:0] gain, input logic [6:0] db,
                             input logic [7:0] slew, input logic [15:0] tmo,
                             input logic [15:0] per, input logic li, input logic ri);
        write_reg(REG_SPEED_LIMIT, {1'b0, lim});
        write_reg(REG_SPEED_GAIN, gain);
        write_reg(REG_DEADBAND, {9'd0, db});
        write_reg(REG_SLEW_STEP, {8'd0, slew});
        write_reg(REG_TIMEOUT_MS, tmo);
        write_reg(REG_LOOP_PERIOD_MS, per);
        write_reg(REG_LEFT_INVERT, {15'd0, li});
        write_reg(REG_RIGHT_INVERT, {15'd0, ri});
        cfg_we <= 1'b0;
        cur_limit = lim;
    endtask

    // Speeds cluster on the extremes and around the clamp limit.
    function automatic logic [15:0] pick_speed;
        int v;
        case ($urandom_range(7))
            0: v = 32767;
            1: v = -32768;
            2: v = 0;
            3: v = int'(cur_limit);
            4: v = -int'(cur_limit);
            5: v = int'(cur_limit) + 1;
            6: v = -int'(cur_limit) - 1;
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    initial
    begin : stimulus
        logic [14:0] lim;
        logic [15:0] gain;
        logic [6:0]  db;
        logic [7:0]  slew;
        logic [15:0] tmo;
        logic [15:0] per;
        int          cmd_pct;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, saturation, inversion and a short watchdog.
        configure(15'h7FFF, 16'hFFFF, 7'd0, 8'd254, 16'd3, 16'd1, 1'b1, 1'b0);
        push_beat(CMD_SPEED, 16'h7FFF, 16'h8000);
        push_beat(CMD_TICK, 16'hFFFF, 16'h0000);
        push_beat(CMD_TICK, 16'h0000, 16'hFFFF);
        push_beat(CMD_SPEED, 16'h8000, 16'h7FFF);
        repeat (5) push_beat(CMD_TICK, 16'h0000, 16'h0000);
        push_beat(CMD_SPEED, 16'h0000, 16'h0000);
        push_beat(CMD_TICK, 16'h0000, 16'h0000);
        push_beat(CMD_SPEED, 16'h0001, 16'hFFFF);
        push_beat(CMD_TICK, 16'h0000, 16'h0000);
        push_beat(CMD_SPEED, 16'h4000, 16'hC000);
        push_beat(CMD_TICK, 16'h0000, 16'h0000);
        push_beat(CMD_TICK, 16'h0000, 16'h0000);
        drain();

        // Random phases, each with its own register setting and one of four idling patterns.
        for (int p = 0; p < 12; p++)
        begin
            lim = (p == 0) ? SPEED_LIMIT_RST : (p == 1) ? 15'd0 : (p == 2) ? 15'h7FFF :
                  15'($urandom_range(32767));
            gain = (p == 0) ? SPEED_GAIN_RST : (p == 3) ? 16'hFFFF : (p == 4) ? 16'd0 :
                   16'($urandom_range(40000));
            db = (p == 0) ? DEADBAND_RST : (p == 2) ? 7'd127 : (p == 5) ? 7'd0 :
                 7'($urandom_range(20));
            slew = (p == 0) ? SLEW_STEP_RST : (p == 3) ? 8'd0 : (p == 4) ? 8'd255 :
                   (p == 6) ? 8'd1 : 8'($urandom_range(1, 40));
            tmo = (p == 0) ? TIMEOUT_MS_RST : (p == 5) ? 16'd0 : (p == 6) ? 16'hFFFF :
                  16'($urandom_range(5, 60));
            per = (p == 0) ? LOOP_PERIOD_MS_RST : (p == 7) ? 16'd0 : (p == 8) ? 16'hFFFF :
                  16'($urandom_range(1, 6));
            configure(lim, gain, db, slew, tmo, per,
                      (p == 0) ? 1'b0 : p[0], (p == 0) ? 1'b0 : p[1]);
            case (p % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct = 73;
                    stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct = 73;
                end
                default:
                begin
                    send_gap_pct = 32;
                    stall_pct = 32;
                end
            endcase
            cmd_pct = $urandom_range(3, 25);
            for (int n = 0; n < 152; n++)
            begin
                if ($urandom_range(99) < cmd_pct)
                    push_beat(CMD_SPEED, pick_speed(), pick_speed());
                else
                    push_beat(CMD_TICK, 16'($urandom), 16'($urandom));
            end
            drain();
            send_gap_pct = 0;
            stall_pct = 0;
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop if the handshakes hang.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
